[sv/hds_pkg.sv]
`default_nettype none
package hds_pkg;

    // dimension arithmetic width, covers the largest frame size
    localparam int DIM_BITS      = 14;
    localparam int DIM_REG_BITS  = 11;
    localparam int DT_BITS       = 16;
    localparam int DT_SHIFT      = 16;
    localparam int ACC_BITS      = 40;
    localparam int CFG_BITS      = 16;
    localparam int CFG_IDX_BITS  = 2;

    // result ordering: backlog limit and results released per pixel
    localparam int VQ_DEPTH      = 32;
    localparam int VQ_BITS       = 6;
    localparam int POP_MAX       = 4;
    localparam int GROUP_MAX     = 9;

    // result buffer and job queue
    localparam int BUF_DEPTH     = 64;
    localparam int BUF_AW        = 6;
    localparam int PTR_BITS      = 7;
    localparam int JOB_DEPTH     = 8;
    localparam int JOB_AW        = 3;

    localparam logic [DT_BITS-1:0]      TIME_STEP_RESET = 16'd15729;
    localparam logic [DIM_REG_BITS-1:0] DIM_RESET       = 11'd512;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_TIME_STEP    = 2'd0,
        REG_IMAGE_WIDTH  = 2'd1,
        REG_IMAGE_HEIGHT = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic       top;
        logic       bot;
        logic       left;
        logic       right;
        logic       last_px;
        logic [3:0] kept;
        logic [3:0] group;
    } job_ctl_t;

    typedef struct packed {
        logic [PTR_BITS-1:0] popped_ptr;
        logic                mark_set;
        logic [BUF_AW-1:0]   mark_slot;
    } front_stat_t;

    typedef struct packed {
        logic                job_taken;
        logic [PTR_BITS-1:0] rd_ptr;
    } back_stat_t;

endpackage
`default_nettype wire

[sv/heat_diffusion_stencil_step.sv]
`default_nettype none
// channel   | direction | beat contents
// ----------+-----------+------------------------------------------------------
// input     | in        | pixel_in, frame_start (in_valid / in_ready)
// output    | out       | pixel_out, out_col, out_row, run_last, frame_done,
//           |           | error_sum (out_valid / out_ready)
// config    | in        | cfg_write, cfg_index, cfg_data (no handshake)
//
// one input beat per cycle while in_ready is high; the front pipeline (line
// store read, laplacian, multiply by dt, shift and saturate) never stalls
// the back expands each interior pixel into up to 9 result beats at one beat
// per cycle, so border rows and columns cost extra cycles on the output side
// reset clears counters, window, accumulator and queues; line stores need none
// in_ready drops when the 64 entry result buffer or the 8 entry job queue
// cannot take the worst case group of a new pixel
module heat_diffusion_stencil_step #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int PIXEL_BITS = 24
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   in_valid,
    output logic                                  in_ready,
    input  wire  signed [PIXEL_BITS-1:0]          pixel_in,
    input  wire                                   frame_start,
    output logic                                  out_valid,
    input  wire                                   out_ready,
    output logic signed [PIXEL_BITS-1:0]          pixel_out,
    output logic [$clog2(MAX_WIDTH)-1:0]          out_col,
    output logic [$clog2(MAX_HEIGHT)-1:0]         out_row,
    output logic                                  run_last,
    output logic                                  frame_done,
    output logic [hds_pkg::ACC_BITS-1:0]          error_sum,
    input  wire                                   cfg_write,
    input  wire  [hds_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  wire  [hds_pkg::CFG_BITS-1:0]          cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    // job payload: new value, interior column, interior row, accumulator
    localparam int JW = PIXEL_BITS + CW + RW + hds_pkg::ACC_BITS;
    localparam int QW = $bits(hds_pkg::job_ctl_t) + JW;

    // configuration registers
    logic [hds_pkg::DT_BITS-1:0]      time_step_reg;
    logic [hds_pkg::DIM_REG_BITS-1:0] image_width_reg;
    logic [hds_pkg::DIM_REG_BITS-1:0] image_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_step_reg    <= hds_pkg::TIME_STEP_RESET;
            image_width_reg  <= hds_pkg::DIM_RESET;
            image_height_reg <= hds_pkg::DIM_RESET;
        end
        else if (cfg_write)
        begin
            unique case (hds_pkg::cfg_reg_t'(cfg_index))
                hds_pkg::REG_TIME_STEP:    time_step_reg    <= cfg_data;
                hds_pkg::REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[hds_pkg::DIM_REG_BITS-1:0];
                hds_pkg::REG_IMAGE_HEIGHT: image_height_reg <= cfg_data[hds_pkg::DIM_REG_BITS-1:0];
                default:                   ;
            endcase
        end
    end

    // front to queue
    logic                 job_push;
    hds_pkg::job_ctl_t    job_ctl_in;
    logic [JW-1:0]        job_data_in;
    // queue to back
    logic                 job_valid;
    logic [QW-1:0]        job_head;
    hds_pkg::job_ctl_t    job_ctl_out;
    logic [JW-1:0]        job_data_out;
    // cross status
    hds_pkg::front_stat_t front_stat;
    hds_pkg::back_stat_t  back_stat;

    assign {job_ctl_out, job_data_out} = job_head;

    hds_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .PIXEL_BITS (PIXEL_BITS),
        .CW         (CW),
        .RW         (RW),
        .JW         (JW)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .pixel_in     (pixel_in),
        .frame_start  (frame_start),
        .time_step    (time_step_reg),
        .image_width  (image_width_reg),
        .image_height (image_height_reg),
        .job_push     (job_push),
        .job_ctl      (job_ctl_in),
        .job_data     (job_data_in),
        .back_stat    (back_stat),
        .front_stat   (front_stat)
    );

    hds_job_fifo #(
        .WIDTH (QW)
    ) u_job_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (job_push),
        .push_data  ({job_ctl_in, job_data_in}),
        .pop        (back_stat.job_taken),
        .head_valid (job_valid),
        .head_data  (job_head)
    );

    hds_back #(
        .PIXEL_BITS (PIXEL_BITS),
        .CW         (CW),
        .RW         (RW),
        .JW         (JW)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_valid  (job_valid),
        .job_ctl    (job_ctl_out),
        .job_data   (job_data_out),
        .front_stat (front_stat),
        .back_stat  (back_stat),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .pixel_out  (pixel_out),
        .out_col    (out_col),
        .out_row    (out_row),
        .run_last   (run_last),
        .frame_done (frame_done),
        .error_sum  (error_sum)
    );

endmodule
`default_nettype wire

[sv/hds_front.sv]
`default_nettype none
module hds_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int PIXEL_BITS = 24,
    parameter int CW         = 10,
    parameter int RW         = 10,
    parameter int JW         = 84
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   in_valid,
    output logic                                  in_ready,
    input  wire  signed [PIXEL_BITS-1:0]          pixel_in,
    input  wire                                   frame_start,
    input  wire         [hds_pkg::DT_BITS-1:0]    time_step,
    input  wire         [hds_pkg::DIM_REG_BITS-1:0] image_width,
    input  wire         [hds_pkg::DIM_REG_BITS-1:0] image_height,
    output logic                                  job_push,
    output hds_pkg::job_ctl_t                     job_ctl,
    output logic        [JW-1:0]                  job_data,
    input  hds_pkg::back_stat_t                   back_stat,
    output hds_pkg::front_stat_t                  front_stat
);

    localparam int LW = PIXEL_BITS + 4;
    localparam int PW = LW + hds_pkg::DT_BITS + 1;
    localparam int DW = LW + 1;
    localparam int NW = LW + 2;
    localparam int DB = hds_pkg::DIM_BITS;
    localparam int PB = hds_pkg::PTR_BITS;
    localparam int VB = hds_pkg::VQ_BITS;
    localparam logic signed [NW-1:0] PMAX_W =
        $signed({{(NW-PIXEL_BITS+1){1'b0}}, {(PIXEL_BITS-1){1'b1}}});
    localparam logic signed [NW-1:0] PMIN_W = -PMAX_W - NW'(1);

    // position and bookkeeping state
    logic [CW-1:0]              col_reg;
    logic [RW-1:0]              row_reg;
    logic [VB-1:0]              vq_reg;
    logic [PB-1:0]              kept_ptr_reg;
    logic [PB-1:0]              popped_ptr_reg;
    logic [hds_pkg::JOB_AW:0]   jcred_reg;

    logic [DB-1:0] wi, hi, wc, hc, c_ext, r_ext;
    logic [CW-1:0] c0;
    logic [RW-1:0] r0;
    logic          interior, accept;
    logic [1:0]    nr, nc;
    logic [3:0]    group;
    logic [VB-1:0] room, kept6, vq1, npop, vq_next;
    logic [PB-1:0] pending, popped_sum;
    logic [CW-1:0] col_next;
    logic [RW-1:0] row_next;
    hds_pkg::job_ctl_t ctl0;
    logic [hds_pkg::JOB_AW:0] jcred_next;

    always_comb
    begin
        wi = DB'(image_width);
        hi = DB'(image_height);
        wc = (wi < DB'(3)) ? DB'(3) : ((wi > DB'(MAX_WIDTH)) ? DB'(MAX_WIDTH) : wi);
        hc = (hi < DB'(3)) ? DB'(3) : ((hi > DB'(MAX_HEIGHT)) ? DB'(MAX_HEIGHT) : hi);
        c0 = frame_start ? '0 : col_reg;
        r0 = frame_start ? '0 : row_reg;
        c_ext = DB'(c0);
        r_ext = DB'(r0);
        interior = (c_ext >= DB'(2)) && (r_ext >= DB'(2))
                   && (c_ext <= wc - DB'(1)) && (r_ext <= hc - DB'(1));
        ctl0.top     = (r_ext == DB'(2));
        ctl0.bot     = (r_ext == hc - DB'(1));
        ctl0.left    = (c_ext == DB'(2));
        ctl0.right   = (c_ext == wc - DB'(1));
        ctl0.last_px = ctl0.right && ctl0.bot;
        nr = 2'd1 + 2'(ctl0.top) + 2'(ctl0.bot);
        nc = 2'd1 + 2'(ctl0.left) + 2'(ctl0.right);
        group = interior ? (4'(nr) * 4'(nc)) : 4'd0;
        ctl0.group = group;
        // results beyond the backlog limit are dropped
        room  = VB'(hds_pkg::VQ_DEPTH) - vq_reg;
        kept6 = (VB'(group) < room) ? VB'(group) : room;
        ctl0.kept = kept6[3:0];
        vq1  = vq_reg + kept6;
        npop = (vq1 < VB'(hds_pkg::POP_MAX)) ? vq1 : VB'(hds_pkg::POP_MAX);
        vq_next = vq1 - npop;
        popped_sum = popped_ptr_reg + PB'(npop);
        pending = kept_ptr_reg - back_stat.rd_ptr;
        in_ready = (pending <= PB'(hds_pkg::BUF_DEPTH - hds_pkg::GROUP_MAX))
                   && (jcred_reg < (hds_pkg::JOB_AW+1)'(hds_pkg::JOB_DEPTH));
        accept = in_valid && in_ready;
        if (c_ext >= wc - DB'(1))
        begin
            col_next = '0;
            row_next = (r_ext >= hc - DB'(1)) ? '0 : r0 + RW'(1);
        end
        else
        begin
            col_next = c0 + CW'(1);
            row_next = r0;
        end
        jcred_next = jcred_reg
                     + (hds_pkg::JOB_AW+1)'(accept && (kept6 != '0))
                     - (hds_pkg::JOB_AW+1)'(back_stat.job_taken);
        front_stat.popped_ptr = popped_ptr_reg;
        front_stat.mark_set   = accept && (npop != '0);
        front_stat.mark_slot  = hds_pkg::BUF_AW'(popped_sum - PB'(1));
    end

    // line stores
    logic signed [PIXEL_BITS-1:0] upper_mem [MAX_WIDTH];
    logic signed [PIXEL_BITS-1:0] middle_mem [MAX_WIDTH];
    logic signed [PIXEL_BITS-1:0] top_raw_reg, mid_raw_reg;

    // pipeline registers
    logic                         s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic [CW-1:0]                s1_idx_reg;
    logic signed [PIXEL_BITS-1:0] s1_pix_reg;
    logic                         s1_clr_reg, s2_clr_reg;
    logic                         s1_int_reg, s2_int_reg;
    logic [CW-1:0]                s1_x_reg, s2_x_reg, s3_x_reg;
    logic [RW-1:0]                s1_y_reg, s2_y_reg, s3_y_reg;
    hds_pkg::job_ctl_t            s1_ctl_reg, s2_ctl_reg, s3_ctl_reg;
    logic signed [LW-1:0]         s2_lap_reg;
    logic signed [PIXEL_BITS-1:0] s2_ctr_reg, s3_ctr_reg;
    logic signed [PW-1:0]         s3_prod_reg;
    logic [hds_pkg::ACC_BITS-1:0] acc_reg, acc_next;

    // window and upper-store bypass
    logic signed [PIXEL_BITS-1:0] w1_reg, w3_reg, w4_reg, w5_reg;
    logic                         fwd_valid_reg;
    logic [CW-1:0]                fwd_idx_reg;
    logic signed [PIXEL_BITS-1:0] fwd_data_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            top_raw_reg <= upper_mem[c0];
            mid_raw_reg <= middle_mem[c0];
            middle_mem[c0] <= pixel_in;
        end
        if (s1_valid_reg)
        begin
            upper_mem[s1_idx_reg] <= mid_raw_reg;
        end
    end

    logic signed [PIXEL_BITS-1:0] top_v;
    logic signed [LW-1:0]         lap;
    logic [LW-1:0]                alap;
    logic [hds_pkg::ACC_BITS:0]   asum;
    logic [hds_pkg::ACC_BITS-1:0] acc_base;
    logic signed [PW-1:0]         prod;
    logic signed [DW-1:0]         delta;
    logic signed [NW-1:0]         nvw;
    logic signed [PIXEL_BITS-1:0] nv;

    always_comb
    begin
        top_v = (fwd_valid_reg && (fwd_idx_reg == s1_idx_reg)) ? fwd_data_reg : top_raw_reg;
        lap = LW'(w3_reg) + LW'(w5_reg) + LW'(w1_reg) + LW'(mid_raw_reg)
              - (LW'(w4_reg) <<< 2);
        prod = PW'(s2_lap_reg) * PW'($signed({1'b0, time_step}));
        alap = s2_lap_reg[LW-1] ? $unsigned(LW'(-s2_lap_reg)) : $unsigned(s2_lap_reg);
        acc_base = s2_clr_reg ? '0 : acc_reg;
        asum = {1'b0, acc_base} + (hds_pkg::ACC_BITS+1)'(alap);
        if (s2_int_reg)
        begin
            acc_next = asum[hds_pkg::ACC_BITS] ? '1 : asum[hds_pkg::ACC_BITS-1:0];
        end
        else
        begin
            acc_next = acc_base;
        end
        // floor division by 2^16 is an arithmetic shift
        delta = DW'(s3_prod_reg >>> hds_pkg::DT_SHIFT);
        nvw = NW'(s3_ctr_reg) + NW'(delta);
        if (nvw > PMAX_W)
        begin
            nv = PIXEL_BITS'(PMAX_W);
        end
        else if (nvw < PMIN_W)
        begin
            nv = PIXEL_BITS'(PMIN_W);
        end
        else
        begin
            nv = PIXEL_BITS'(nvw);
        end
        job_push = s3_valid_reg && (s3_ctl_reg.kept != 4'd0);
        job_ctl  = s3_ctl_reg;
        job_data = {nv, s3_x_reg, s3_y_reg, acc_reg};
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_idx_reg <= c0;
            s1_pix_reg <= pixel_in;
            s1_clr_reg <= (c0 == '0) && (r0 == '0);
            s1_int_reg <= interior;
            s1_x_reg   <= c0 - CW'(1);
            s1_y_reg   <= r0 - RW'(1);
            s1_ctl_reg <= ctl0;
        end
        s2_lap_reg  <= lap;
        s2_ctr_reg  <= w4_reg;
        s2_clr_reg  <= s1_clr_reg;
        s2_int_reg  <= s1_int_reg;
        s2_x_reg    <= s1_x_reg;
        s2_y_reg    <= s1_y_reg;
        s2_ctl_reg  <= s1_ctl_reg;
        s3_prod_reg <= prod;
        s3_ctr_reg  <= s2_ctr_reg;
        s3_x_reg    <= s2_x_reg;
        s3_y_reg    <= s2_y_reg;
        s3_ctl_reg  <= s2_ctl_reg;
        fwd_idx_reg  <= s1_idx_reg;
        fwd_data_reg <= mid_raw_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg        <= '0;
            row_reg        <= '0;
            vq_reg         <= '0;
            kept_ptr_reg   <= '0;
            popped_ptr_reg <= '0;
            jcred_reg      <= '0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s3_valid_reg   <= 1'b0;
            fwd_valid_reg  <= 1'b0;
            acc_reg        <= '0;
            w1_reg         <= '0;
            w3_reg         <= '0;
            w4_reg         <= '0;
            w5_reg         <= '0;
        end
        else
        begin
            s1_valid_reg  <= accept;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            fwd_valid_reg <= s1_valid_reg;
            jcred_reg     <= jcred_next;
            if (accept)
            begin
                col_reg        <= col_next;
                row_reg        <= row_next;
                vq_reg         <= vq_next;
                kept_ptr_reg   <= kept_ptr_reg + PB'(kept6);
                popped_ptr_reg <= popped_sum;
            end
            if (s1_valid_reg)
            begin
                w1_reg <= w4_reg;
                w3_reg <= top_v;
                w4_reg <= mid_raw_reg;
                w5_reg <= s1_pix_reg;
            end
            if (s2_valid_reg)
            begin
                acc_reg <= acc_next;
            end
        end
    end

endmodule
`default_nettype wire

[sv/hds_job_fifo.sv]
`default_nettype none
module hds_job_fifo #(
    parameter int WIDTH = 97
) (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              push,
    input  wire  [WIDTH-1:0] push_data,
    input  wire              pop,
    output logic             head_valid,
    output logic [WIDTH-1:0] head_data
);

    logic [WIDTH-1:0]          slot_reg [hds_pkg::JOB_DEPTH];
    logic [hds_pkg::JOB_AW:0]  wr_reg, rd_reg;

    assign head_valid = (wr_reg != rd_reg);
    assign head_data  = slot_reg[rd_reg[hds_pkg::JOB_AW-1:0]];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg[hds_pkg::JOB_AW-1:0]] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0;
            rd_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + (hds_pkg::JOB_AW+1)'(1);
            end
            if (pop)
            begin
                rd_reg <= rd_reg + (hds_pkg::JOB_AW+1)'(1);
            end
        end
    end

endmodule
`default_nettype wire

[sv/hds_back.sv]
`default_nettype none
module hds_back #(
    parameter int PIXEL_BITS = 24,
    parameter int CW         = 10,
    parameter int RW         = 10,
    parameter int JW         = 84
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 job_valid,
    input  hds_pkg::job_ctl_t                   job_ctl,
    input  wire  [JW-1:0]                       job_data,
    input  hds_pkg::front_stat_t                front_stat,
    output hds_pkg::back_stat_t                 back_stat,
    output logic                                out_valid,
    input  wire                                 out_ready,
    output logic signed [PIXEL_BITS-1:0]        pixel_out,
    output logic [CW-1:0]                       out_col,
    output logic [RW-1:0]                       out_row,
    output logic                                run_last,
    output logic                                frame_done,
    output logic [hds_pkg::ACC_BITS-1:0]        error_sum
);

    localparam int EW = PIXEL_BITS + CW + RW + 1 + hds_pkg::ACC_BITS;
    localparam int PB = hds_pkg::PTR_BITS;
    localparam int AB = hds_pkg::ACC_BITS;

    // job fields
    logic signed [PIXEL_BITS-1:0] j_pix;
    logic [CW-1:0]                j_x;
    logic [RW-1:0]                j_y;
    logic [AB-1:0]                j_err;

    // expansion walk over the copy grid
    logic [3:0] cnt_reg;
    logic [1:0] ri_reg, ci_reg;
    logic [1:0] start_r, start_c, cur_r, cur_c, nxt_r, nxt_c;
    logic [CW-1:0] e_col;
    logic [RW-1:0] e_row;
    logic          e_done, job_end;
    logic [EW-1:0] e_word;

    always_comb
    begin
        {j_pix, j_x, j_y, j_err} = job_data;
        start_r = job_ctl.top  ? 2'd0 : 2'd1;
        start_c = job_ctl.left ? 2'd0 : 2'd1;
        cur_r = (cnt_reg == 4'd0) ? start_r : ri_reg;
        cur_c = (cnt_reg == 4'd0) ? start_c : ci_reg;
        case (cur_r)
            2'd0:    e_row = '0;
            2'd1:    e_row = j_y;
            default: e_row = j_y + RW'(1);
        endcase
        case (cur_c)
            2'd0:    e_col = '0;
            2'd1:    e_col = j_x;
            default: e_col = j_x + CW'(1);
        endcase
        if ((cur_c == 2'd0) || ((cur_c == 2'd1) && job_ctl.right))
        begin
            nxt_c = cur_c + 2'd1;
            nxt_r = cur_r;
        end
        else
        begin
            nxt_c = start_c;
            nxt_r = cur_r + 2'd1;
        end
        e_done  = job_ctl.last_px && ((cnt_reg + 4'd1) == job_ctl.group);
        job_end = (cnt_reg + 4'd1) == job_ctl.kept;
        e_word  = {j_pix, e_col, e_row, e_done, e_done ? j_err : {AB{1'b0}}};
    end

    // result buffer
    logic [EW-1:0]                 buf_mem [hds_pkg::BUF_DEPTH];
    logic [hds_pkg::BUF_DEPTH-1:0] mark_reg, mark_next;
    logic [PB-1:0]                 wr_ptr_reg, rd_ptr_reg;
    logic                          rvalid_reg, rlast_reg;
    logic [EW-1:0]                 rdata_reg;
    logic                          ovalid_reg, issue, load;

    always_comb
    begin
        load  = rvalid_reg && (!ovalid_reg || out_ready);
        // only entries already released to the output order may leave
        issue = (rd_ptr_reg != wr_ptr_reg) && (rd_ptr_reg != front_stat.popped_ptr)
                && (!rvalid_reg || load);
        mark_next = mark_reg;
        if (issue)
        begin
            mark_next[rd_ptr_reg[hds_pkg::BUF_AW-1:0]] = 1'b0;
        end
        if (front_stat.mark_set)
        begin
            mark_next[front_stat.mark_slot] = 1'b1;
        end
        back_stat.job_taken = job_valid && job_end;
        back_stat.rd_ptr    = rd_ptr_reg;
        out_valid = ovalid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (job_valid)
        begin
            buf_mem[wr_ptr_reg[hds_pkg::BUF_AW-1:0]] <= e_word;
        end
        if (issue)
        begin
            rdata_reg <= buf_mem[rd_ptr_reg[hds_pkg::BUF_AW-1:0]];
            rlast_reg <= mark_reg[rd_ptr_reg[hds_pkg::BUF_AW-1:0]];
        end
        if (load)
        begin
            {pixel_out, out_col, out_row, frame_done, error_sum} <= rdata_reg;
            run_last <= rlast_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            ri_reg     <= '0;
            ci_reg     <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            mark_reg   <= '0;
            rvalid_reg <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (job_valid)
            begin
                wr_ptr_reg <= wr_ptr_reg + PB'(1);
                cnt_reg    <= job_end ? 4'd0 : cnt_reg + 4'd1;
                ri_reg     <= nxt_r;
                ci_reg     <= nxt_c;
            end
            if (issue)
            begin
                rd_ptr_reg <= rd_ptr_reg + PB'(1);
            end
            mark_reg <= mark_next;
            if (issue)
            begin
                rvalid_reg <= 1'b1;
            end
            else if (load)
            begin
                rvalid_reg <= 1'b0;
            end
            if (load)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire
